/* rtl/random_sample_set_table_top_assert.svh */
// ----------------------------------------------------------------------------
// random_sample_set_table_top_assert.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef RANDOM_SAMPLE_SET_TABLE_TOP_ASSERT_SVH
`define RANDOM_SAMPLE_SET_TABLE_TOP_ASSERT_SVH

// clocked check, disabled while reset is asserted
`define RSST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define RSST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rsst_pkg.sv */
// ----------------------------------------------------------------------------
// rsst_pkg
// Types, constants and handshake structs for the random sample set table.
// ----------------------------------------------------------------------------
package rsst_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int DRAW_W   = 16;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int STEP_W   = $clog2(DRAW_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    logic [DRAW_W-1:0]        random_draw;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] sample_value;
    logic [CNT_W-1:0]         member_count;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_DIV,
    S_SAMP_RD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic div_step;
    logic move_rd;
    logic move_wr;
    logic samp_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              scan_done;
    logic              hit;
    logic              empty;
    logic              div_last;
    logic              out_free;
  } sts_t;

endpackage

/* rtl/rsst_ram.sv */
// ----------------------------------------------------------------------------
// rsst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rsst_ctrl.sv */
// ----------------------------------------------------------------------------
// rsst_ctrl
// Sequencer: steps one item through dispatch, scan, move, remainder, sample read and response.
// ----------------------------------------------------------------------------
module rsst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rsst_pkg::sts_t sts,
  output rsst_pkg::cmd_t cmd
);

  rsst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsst_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rsst_pkg::S_DISPATCH;
      end
      rsst_pkg::S_DISPATCH: begin
        unique case (sts.func)
          rsst_pkg::FUNC_INSERT, rsst_pkg::FUNC_REMOVE: state_nxt = rsst_pkg::S_SCAN;
          rsst_pkg::FUNC_SAMPLE: begin
            state_nxt = sts.empty ? rsst_pkg::S_RESP : rsst_pkg::S_DIV;
          end
          default: state_nxt = rsst_pkg::S_RESP;
        endcase
      end
      rsst_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.func == rsst_pkg::FUNC_REMOVE && sts.hit) begin
            state_nxt = rsst_pkg::S_MOVE_RD;
          end else begin
            state_nxt = rsst_pkg::S_RESP;
          end
        end
      end
      rsst_pkg::S_MOVE_RD: state_nxt = rsst_pkg::S_MOVE_WR;
      rsst_pkg::S_MOVE_WR: state_nxt = rsst_pkg::S_RESP;
      rsst_pkg::S_DIV: begin
        if (sts.div_last) state_nxt = rsst_pkg::S_SAMP_RD;
      end
      rsst_pkg::S_SAMP_RD: state_nxt = rsst_pkg::S_RESP;
      rsst_pkg::S_RESP: begin
        if (sts.out_free) state_nxt = rsst_pkg::S_IDLE;
      end
      default: state_nxt = rsst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      rsst_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      rsst_pkg::S_SCAN:    cmd.scan_step = 1'b1;
      rsst_pkg::S_MOVE_RD: cmd.move_rd   = 1'b1;
      rsst_pkg::S_MOVE_WR: cmd.move_wr   = 1'b1;
      rsst_pkg::S_DIV:     cmd.div_step  = 1'b1;
      rsst_pkg::S_SAMP_RD: cmd.samp_rd   = 1'b1;
      rsst_pkg::S_RESP:    cmd.commit    = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/rsst_dp.sv */
// ----------------------------------------------------------------------------
// rsst_dp
// Datapath: member store, scan compare, bit-serial remainder, result register.
// ----------------------------------------------------------------------------
module rsst_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  rsst_pkg::in_t  in_data,
  input  rsst_pkg::cmd_t cmd,
  output rsst_pkg::sts_t sts,
  output logic           out_valid,
  output rsst_pkg::out_t out_data,
  input  logic           out_stall
);

  localparam int CNT_W  = rsst_pkg::CNT_W;
  localparam int ADDR_W = rsst_pkg::ADDR_W;
  localparam int DATA_W = rsst_pkg::DATA_W;
  localparam int DRAW_W = rsst_pkg::DRAW_W;
  localparam int STEP_W = rsst_pkg::STEP_W;

  logic [rsst_pkg::FUNC_W-1:0] func_r;
  logic [DATA_W-1:0]           value_r;
  logic [DRAW_W-1:0]           draw_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt, commit_cnt;
  logic [CNT_W-1:0]            idx_r;
  logic                        pend_r, pend_nxt;
  logic [ADDR_W-1:0]           slot_pipe_r;
  logic                        hit_r;
  logic [ADDR_W-1:0]           hit_slot_r;
  logic [CNT_W-1:0]            rem_r;
  logic [STEP_W-1:0]           step_r;
  logic                        out_valid_r, out_valid_nxt;
  rsst_pkg::out_t              out_data_r;

  logic                        issue;
  logic                        full, empty;
  logic [CNT_W-1:0]            last_idx;
  logic [CNT_W:0]              trial;
  logic [CNT_W-1:0]            rem_nxt;
  rsst_pkg::status_t           res_status;
  logic [DATA_W-1:0]           res_sample;
  logic                        wr_ins;

  logic                        wr_en, rd_en;
  logic [ADDR_W-1:0]           wr_addr, rd_addr;
  logic [DATA_W-1:0]           wr_data, rd_data;

  assign full     = (cnt_r == CNT_W'(rsst_pkg::CAPACITY));
  assign empty    = (cnt_r == '0);
  assign issue    = cmd.scan_step && (idx_r < cnt_r);
  assign last_idx = cnt_r - CNT_W'(1);

  // restoring remainder step
  assign trial   = {rem_r, draw_r[DRAW_W-1]};
  assign rem_nxt = (trial >= {1'b0, cnt_r}) ? CNT_W'(trial - {1'b0, cnt_r})
                                             : trial[CNT_W-1:0];

  always_comb begin
    res_status = rsst_pkg::ST_DONE;
    res_sample = '0;
    commit_cnt = cnt_r;
    wr_ins     = 1'b0;
    unique case (func_r)
      rsst_pkg::FUNC_INSERT: begin
        if (hit_r) begin
          res_status = rsst_pkg::ST_MISS;
        end else if (full) begin
          res_status = rsst_pkg::ST_FULL;
        end else begin
          wr_ins     = 1'b1;
          commit_cnt = cnt_r + CNT_W'(1);
        end
      end
      rsst_pkg::FUNC_REMOVE: begin
        if (hit_r) begin
          commit_cnt = last_idx;
        end else begin
          res_status = rsst_pkg::ST_MISS;
        end
      end
      rsst_pkg::FUNC_SAMPLE: begin
        if (empty) begin
          res_status = rsst_pkg::ST_EMPTY;
        end else begin
          res_sample = rd_data;
        end
      end
      default: ;
    endcase
  end

  assign cnt_nxt       = cmd.commit ? commit_cnt : cnt_r;
  assign pend_nxt      = cmd.load ? 1'b0 : issue;
  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);

  assign wr_en   = cmd.move_wr || (cmd.commit && wr_ins);
  assign wr_addr = cmd.move_wr ? hit_slot_r : cnt_r[ADDR_W-1:0];
  assign wr_data = cmd.move_wr ? rd_data : value_r;

  assign rd_en = issue || cmd.move_rd || cmd.samp_rd;

  always_comb begin
    priority if (cmd.move_rd) begin
      rd_addr = last_idx[ADDR_W-1:0];
    end else if (cmd.samp_rd) begin
      rd_addr = rem_r[ADDR_W-1:0];
    end else begin
      rd_addr = idx_r[ADDR_W-1:0];
    end
  end

  rsst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (rsst_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_data.func;
      value_r <= in_data.value;
      draw_r  <= in_data.random_draw;
      idx_r   <= '0;
      hit_r   <= 1'b0;
      rem_r   <= '0;
      step_r  <= '0;
    end else begin
      if (issue) begin
        idx_r       <= idx_r + CNT_W'(1);
        slot_pipe_r <= idx_r[ADDR_W-1:0];
      end
      if (pend_r && (rd_data == value_r)) begin
        hit_r      <= 1'b1;
        hit_slot_r <= slot_pipe_r;
      end
      if (cmd.div_step) begin
        rem_r  <= rem_nxt;
        draw_r <= {draw_r[DRAW_W-2:0], 1'b0};
        step_r <= step_r + STEP_W'(1);
      end
    end
    if (cmd.commit) begin
      out_data_r.status       <= res_status;
      out_data_r.sample_value <= $signed(res_sample);
      out_data_r.member_count <= commit_cnt;
    end
  end

  assign sts.func      = func_r;
  assign sts.scan_done = !(idx_r < cnt_r) && !pend_r;
  assign sts.hit       = hit_r;
  assign sts.empty     = empty;
  assign sts.div_last  = (step_r == STEP_W'(DRAW_W - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/random_sample_set_table_top.sv */
// ----------------------------------------------------------------------------
// random_sample_set_table_top
// Set of distinct 32-bit values with insert, remove and random sample.
// ----------------------------------------------------------------------------
// Input beat: func (insert, remove, sample), value, random_draw. Taken when
// in_valid is high and in_stall is low. One result beat per input beat:
// status, sample_value, member_count, presented on out_valid/out_data.
// One item is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register.
// Insert and remove scan the member store through its single read port, one
// entry a cycle; a remove that hits then moves the last member into the freed
// slot. Sample reduces the draw by a bit-serial remainder unit, one bit a
// cycle, and reads the member at the remainder as the sample.
// An unused func code goes straight to the response with status done.
// A finished result waits in the output register while out_stall is high; the
// block takes the next item meanwhile and holds its own result until the
// register frees up.
// Reset clears the member count and the output valid. The store itself is not
// cleared; no entry at or above the count is ever read.
// ----------------------------------------------------------------------------
module random_sample_set_table_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rsst_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rsst_pkg::out_t out_data
);

  rsst_pkg::cmd_t cmd;
  rsst_pkg::sts_t sts;

  rsst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

/* rtl/rsst_checker.sv */
// ----------------------------------------------------------------------------
// rsst_checker
// Port-level checks on the random sample set table, bound to the top level.
// ----------------------------------------------------------------------------
`include "random_sample_set_table_top_assert.svh"

module rsst_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input rsst_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input rsst_pkg::out_t out_data
);

  `RSST_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")

  `RSST_ASSERT(a_one_item, clk, rst_n, in_valid && !in_stall |=> in_stall, "second beat taken while item in progress")

  `RSST_ASSERT(a_count_cap, clk, rst_n, out_valid |-> out_data.member_count <= rsst_pkg::CAPACITY, "member count above capacity")

  `RSST_ASSERT(a_empty_cnt, clk, rst_n, out_valid && out_data.status == rsst_pkg::ST_EMPTY |-> out_data.member_count == 0, "empty status with members held")

  `RSST_ASSERT(a_sample_zero, clk, rst_n, out_valid && out_data.status != rsst_pkg::ST_DONE |-> out_data.sample_value == 0, "nonzero sample on failed beat")

endmodule

bind random_sample_set_table_top rsst_checker u_rsst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
